[sv/wrfifo_pkg.sv]
// Shared types, codes and constants for the word ring FIFO.
package wrfifo_pkg;

  // Parameter defaults
  localparam int DEPTH_DEF     = 1024;
  localparam int BURST_MAX_DEF = 64;
  localparam int SIZE_RESET    = 1024;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int BLEN_W  = 7;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 11;
  localparam int LEVEL_W = 11;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_BPOP   = 3'd3,
    CMD_BPUSH  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] data;
    logic [BLEN_W-1:0] burst_len;
    logic [IDX_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data_out;
    logic               ok;
    logic               last;
    logic [LEVEL_W-1:0] level;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_PEEK,
    ST_RDWAIT
  } state_e;

  // Result source select
  typedef enum logic [1:0] {
    RES_READ,
    RES_WRITE,
    RES_FLAG
  } res_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic push_step;
    logic bpush_step;
    logic rd_pop;
    logic rd_peek;
    logic beats_burst;
    logic beats_clear;
    logic beats_dec;
    logic mod_start;
    logic out_load;
    res_e res_sel;
    logic flag_ok;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e op;
    logic empty;
    logic n_zero;
    logic n_gt_fill;
    logic mod_busy;
    logic beats_zero;
    logic out_free;
  } dp_stat_t;

endpackage

[sv/wrfifo_mod.sv]
// Bit-serial remainder unit: peek offset modulo the ring size.
module wrfifo_mod import wrfifo_pkg::*; #(
  parameter int SW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] dividend,
  input  logic [SW-1:0]    divisor,
  output logic             busy,
  output logic [SW-1:0]    rem
);

  localparam int CNTW = $clog2(IDX_W + 1);

  logic [CNTW-1:0]  cnt;
  logic [IDX_W-1:0] sh;
  logic [SW:0]      trial;
  logic [SW:0]      trial_sub;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, sh[IDX_W-1]};
    trial_sub = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(IDX_W);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= dividend;
    end else if (busy) begin
      rem <= trial_sub[SW-1:0];
      sh  <= {sh[IDX_W-2:0], 1'b0};
    end
  end

endmodule

[sv/wrfifo_dp.sv]
// Datapath: ring store, pointers, burst state, peek address and result register.
module wrfifo_dp import wrfifo_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int BURST_MAX = BURST_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  dp_cmd_t          ctl,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam int MW = (SW > BLEN_W) ? SW : BLEN_W;
  localparam logic [SW-1:0] SIZE_RST = SW'((SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET);
  localparam logic [BLEN_W-1:0] BMAX = BLEN_W'(BURST_MAX);

  // Ring state
  logic [SW-1:0]     size;
  logic [AW-1:0]     rp;
  logic [AW-1:0]     wp;
  logic [SW-1:0]     fill;
  logic [SW-1:0]     hwm;      // entries 0..hwm-1 written since last clear
  logic [BLEN_W-1:0] brem;
  logic              bacc;
  logic [BLEN_W-1:0] beats;

  // Latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] data_q;
  logic [BLEN_W-1:0] n_q;
  logic [IDX_W-1:0]  idx_q;

  // Store and read port
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              rd_mask;

  logic [CW-1:0]     cfg_v;
  logic [SW-1:0]     size_cfg;
  logic [SW-1:0]     rp_inc;
  logic [SW-1:0]     wp_inc;
  logic [AW-1:0]     rp_next;
  logic [AW-1:0]     wp_next;
  logic              full;
  logic              bstart;
  logic [BLEN_W-1:0] n1;
  logic              bfit;
  logic              bacc_cur;
  logic [BLEN_W-1:0] brem_after;
  logic              wr_en;
  logic              rd_en;
  logic [SW-1:0]     mod_rem;
  logic              mod_busy;
  logic [SW:0]       pk_sum;
  logic [SW:0]       pk_pos;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     level_v;
  out_item_t         res;

  // Size register decode, zero acts as one, clamp to depth
  always_comb begin
    cfg_v = CW'(cfg_wr_data);
    if (cfg_v == '0) begin
      size_cfg = SW'(1);
    end else if (cfg_v > CW'(DEPTH)) begin
      size_cfg = SW'(DEPTH);
    end else begin
      size_cfg = SW'(cfg_v);
    end
  end

  // Pointer wrap at the runtime size
  always_comb begin
    rp_inc  = SW'(rp) + SW'(1);
    wp_inc  = SW'(wp) + SW'(1);
    rp_next = (rp_inc >= size) ? '0 : rp_inc[AW-1:0];
    wp_next = (wp_inc >= size) ? '0 : wp_inc[AW-1:0];
  end

  // Burst push admission
  always_comb begin
    full       = (fill >= size);
    bstart     = (brem == '0);
    n1         = (n_q == '0) ? BLEN_W'(1) : n_q;
    bfit       = ((MW + 1)'(n1) + (MW + 1)'(fill)) <= (MW + 1)'(size);
    bacc_cur   = bstart ? bfit : bacc;
    brem_after = (bstart ? n1 : brem) - BLEN_W'(1);
    wr_en      = !full && ((ctl.push_step) || (ctl.bpush_step && bacc_cur));
  end

  // Peek slot: read pointer plus reduced offset, wrapped once
  always_comb begin
    pk_sum  = (SW + 1)'(rp) + (SW + 1)'(mod_rem);
    pk_pos  = (pk_sum >= (SW + 1)'(size)) ? pk_sum - (SW + 1)'(size) : pk_sum;
    rd_addr = ctl.rd_peek ? pk_pos[AW-1:0] : rp;
    rd_en   = ctl.rd_pop | ctl.rd_peek;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      size  <= SIZE_RST;
      rp    <= '0;
      wp    <= '0;
      fill  <= '0;
      hwm   <= '0;
      brem  <= '0;
      bacc  <= 1'b0;
      beats <= '0;
    end else if (cfg_wr_en) begin
      size <= size_cfg;
      rp   <= '0;
      wp   <= '0;
      fill <= '0;
      hwm  <= '0;
      brem <= '0;
      bacc <= 1'b0;
    end else begin
      if (wr_en) begin
        wp   <= wp_next;
        fill <= fill + SW'(1);
        if (SW'(wp) == hwm) begin
          hwm <= hwm + SW'(1);
        end
      end else if (ctl.rd_pop) begin
        rp   <= rp_next;
        fill <= fill - SW'(1);
      end
      if (ctl.bpush_step) begin
        brem <= brem_after;
        bacc <= (brem_after == '0) ? 1'b0 : bacc_cur;
      end
      if (ctl.beats_burst) begin
        beats <= n_q - BLEN_W'(1);
      end else if (ctl.beats_clear) begin
        beats <= '0;
      end else if (ctl.beats_dec) begin
        beats <= beats - BLEN_W'(1);
      end
    end
  end

  // Item latch, burst length saturated
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q  <= in_item.cmd;
      data_q <= in_item.data;
      n_q    <= (in_item.burst_len > BMAX) ? BMAX : in_item.burst_len;
      idx_q  <= in_item.index;
    end
  end

  // Store write and registered read; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata   <= mem[rd_addr];
      rd_mask <= (SW'(rd_addr) < hwm);
    end
  end

  wrfifo_mod #(
    .SW (SW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.mod_start),
    .dividend (idx_q),
    .divisor  (size),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // Result assembly
  always_comb begin
    level_v = fill + SW'(wr_en);
    res     = '0;
    res.level = LEVEL_W'(level_v);
    unique case (ctl.res_sel)
      RES_READ: begin
        res.data_out = rd_mask ? rdata : '0;
        res.ok       = 1'b1;
        res.last     = (beats == '0);
      end
      RES_WRITE: begin
        res.ok   = wr_en;
        res.last = 1'b1;
      end
      RES_FLAG: begin
        res.ok   = ctl.flag_ok;
        res.last = 1'b1;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_item <= res;
    end
  end

  // Status to controller
  always_comb begin
    stat.op         = cmd_e'(cmd_q);
    stat.empty      = (fill == '0);
    stat.n_zero     = (n_q == '0);
    stat.n_gt_fill  = (MW'(n_q) > MW'(fill));
    stat.mod_busy   = mod_busy;
    stat.beats_zero = (beats == '0);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

[sv/wrfifo_ctrl.sv]
// Controller: sequences each accepted item through the datapath.
module wrfifo_ctrl import wrfifo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_e state;
  state_e state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.res_sel = RES_FLAG;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          CMD_PUSH: begin
            if (stat.out_free) begin
              ctl.push_step = 1'b1;
              ctl.out_load  = 1'b1;
              ctl.res_sel   = RES_WRITE;
              state_next    = ST_IDLE;
            end
          end
          CMD_POP: begin
            if (!stat.empty) begin
              ctl.rd_pop      = 1'b1;
              ctl.beats_clear = 1'b1;
              state_next      = ST_RDWAIT;
            end else if (stat.out_free) begin
              ctl.out_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          CMD_PEEK: begin
            ctl.mod_start = 1'b1;
            state_next    = ST_MOD;
          end
          CMD_BPOP: begin
            if (!stat.n_zero && !stat.n_gt_fill) begin
              ctl.rd_pop      = 1'b1;
              ctl.beats_burst = 1'b1;
              state_next      = ST_RDWAIT;
            end else if (stat.out_free) begin
              // zero-length burst is accepted, too long a burst refused
              ctl.out_load = 1'b1;
              ctl.flag_ok  = stat.n_zero;
              state_next   = ST_IDLE;
            end
          end
          CMD_BPUSH: begin
            if (stat.out_free) begin
              ctl.bpush_step = 1'b1;
              ctl.out_load   = 1'b1;
              ctl.res_sel    = RES_WRITE;
              state_next     = ST_IDLE;
            end
          end
          default: begin
            // unknown operation: refused, no state change
            if (stat.out_free) begin
              ctl.out_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
        endcase
      end
      ST_MOD: begin
        if (!stat.mod_busy) begin
          state_next = ST_PEEK;
        end
      end
      ST_PEEK: begin
        ctl.rd_peek     = 1'b1;
        ctl.beats_clear = 1'b1;
        state_next      = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          ctl.res_sel  = RES_READ;
          if (!stat.beats_zero) begin
            // overlap the next burst read with this beat
            ctl.rd_pop    = 1'b1;
            ctl.beats_dec = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/word_ring_fifo_with_burst_and_peek.sv]
// Top level of the word ring FIFO with burst and peek access.
//
// Ring FIFO of 32-bit words with a runtime size (buffer_size, 1..DEPTH, zero
// acting as one), written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, as the block does not enforce this. A write empties the
// ring and makes every slot read as zero again, with no clearing pass. One
// item is worked at a time: a push, burst push element or refusal gives its
// result from EXEC, a pop after a store read, a burst pop one word per cycle
// from the store read port while the output is free, and a peek after the
// bit-serial unit reduces the 10-bit offset modulo the size. Results sit in
// an output register, so a stalled result does not hold up the next accept.
module word_ring_fifo_with_burst_and_peek import wrfifo_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int BURST_MAX = BURST_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  wrfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  wrfifo_dp #(
    .DEPTH     (DEPTH),
    .BURST_MAX (BURST_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

[verif/ring_fifo_checker.sv]
// Result checker for the word ring FIFO: tracks ring state and compares every output beat.
module ring_fifo_checker import wrfifo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int BURST_CAP  = BURST_MAX_DEF;

  // Mirror of the ring
  logic [WORD_W-1:0]  ring_mem [RING_DEPTH];
  int unsigned        head;
  int unsigned        tail;
  logic [LEVEL_W-1:0] fill;
  int unsigned        burst_left;
  bit                 burst_admitted;
  int unsigned        ring_size;

  // Results still owed by the block, oldest first
  out_item_t          due_results [$];

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > RING_DEPTH) return RING_DEPTH;
    return v;
  endfunction

  function automatic void clear_ring();
    int i;
    for (i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    head           = 0;
    tail           = 0;
    fill           = '0;
    burst_left     = 0;
    burst_admitted = 1'b0;
  endfunction

  function automatic bit ring_write(logic [WORD_W-1:0] w);
    if (fill >= ring_size) return 1'b0;
    ring_mem[tail] = w;
    tail++;
    if (tail >= ring_size) tail = 0;
    fill++;
    return 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] ring_read();
    logic [WORD_W-1:0] w;
    w = ring_mem[head];
    head++;
    if (head >= ring_size) head = 0;
    fill--;
    return w;
  endfunction

  // Level is taken after the state change, as the block reports it
  function automatic void owe_result(logic [WORD_W-1:0] d, logic acc, logic fin);
    out_item_t r;
    r.data_out = d;
    r.ok       = acc;
    r.last     = fin;
    r.level    = fill;
    due_results.push_back(r);
  endfunction

  // Work out what one accepted input beat produces
  function automatic void predict_beat(in_item_t it);
    int unsigned       n;
    int unsigned       pos;
    int unsigned       k;
    logic [WORD_W-1:0] w;
    bit                acc;
    n = (it.burst_len > BURST_CAP) ? BURST_CAP : it.burst_len;
    case (it.cmd)
      CMD_PUSH: begin
        acc = ring_write(it.data);
        owe_result('0, acc, 1'b1);
      end
      CMD_POP: begin
        if (fill == 0) begin
          owe_result('0, 1'b0, 1'b1);
        end else begin
          w = ring_read();
          owe_result(w, 1'b1, 1'b1);
        end
      end
      CMD_PEEK: begin
        pos = (head + it.index % ring_size) % ring_size;
        owe_result(ring_mem[pos], 1'b1, 1'b1);
      end
      CMD_BPOP: begin
        if (n == 0) begin
          owe_result('0, 1'b1, 1'b1);
        end else if (n > fill) begin
          owe_result('0, 1'b0, 1'b1);
        end else begin
          for (k = 0; k < n; k++) begin
            w = ring_read();
            owe_result(w, 1'b1, k == n - 1);
          end
        end
      end
      CMD_BPUSH: begin
        // First element of a burst decides admission for the whole burst
        if (burst_left == 0) begin
          if (n == 0) n = 1;
          burst_left     = n;
          burst_admitted = (n + fill <= ring_size);
        end
        acc = burst_admitted ? ring_write(it.data) : 1'b0;
        burst_left--;
        if (burst_left == 0) burst_admitted = 1'b0;
        owe_result('0, acc, 1'b1);
      end
      default: begin
        owe_result('0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void flag_field(string what, logic [WORD_W-1:0] want,
                                     logic [WORD_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, want, got);
  endfunction

  // Compare outgoing beats first, then track config and incoming beats
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ring_size  = clamp_size(CFG_W'(SIZE_RESET));
      clear_ring();
      due_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none due: expected none, actual %h",
                   $realtime, out_item);
        end else begin
          want = due_results.pop_front();
          if (out_item.data_out !== want.data_out)
            flag_field("data_out", want.data_out, out_item.data_out);
          if (out_item.ok !== want.ok)
            flag_field("ok", want.ok, out_item.ok);
          if (out_item.last !== want.last)
            flag_field("last", want.last, out_item.last);
          if (out_item.level !== want.level)
            flag_field("level", want.level, out_item.level);
        end
      end
      if (cfg_wr_en) begin
        ring_size = clamp_size(cfg_wr_data);
        clear_ring();
      end
      if (in_valid && !in_stall) predict_beat(in_item);
    end
    pending = due_results.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the word ring FIFO: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  import wrfifo_pkg::*;

  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 20;
  localparam int BURST_CAP     = BURST_MAX_DEF;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_item     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  int               fail_count;
  int               pending;
  int unsigned      cur_size    = SIZE_RESET;
  bit               hold_req    = 1'b0;
  bit               no_gaps     = 1'b0;

  word_ring_fifo_with_burst_and_peek dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ring_fifo_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk(logic [CMD_W-1:0] c, logic [WORD_W-1:0] d,
                                  logic [BLEN_W-1:0] b, logic [IDX_W-1:0] x);
    in_item_t it;
    it.cmd       = c;
    it.data      = d;
    it.burst_len = b;
    it.index     = x;
    return it;
  endfunction

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Offer one input beat, hold it until taken, then maybe idle
  task automatic send_beat(in_item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write the size register
  task automatic write_size(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_size = (v == '0) ? 1 : (v > DEPTH_DEF) ? DEPTH_DEF : v;
  endtask

  task automatic send_single();
    if ($urandom_range(0, 1))
      send_beat(mk(CMD_PUSH, $urandom(), BLEN_W'($urandom_range(0, 127)),
                   IDX_W'($urandom_range(0, 1023))));
    else
      send_beat(mk(CMD_POP, $urandom(), BLEN_W'($urandom_range(0, 127)),
                   IDX_W'($urandom_range(0, 1023))));
  endtask

  // Burst push: first element carries n, the rest follow; some are cut short or interleaved
  task automatic send_burst_push(output int sent);
    int unsigned n;
    int unsigned beats;
    int unsigned k;
    n     = $urandom_range(0, min_u(cur_size + 1, 70));
    if ($urandom_range(0, 19) == 0) n = $urandom_range(65, 127);
    beats = (n == 0) ? 1 : (n > BURST_CAP) ? BURST_CAP : n;
    if ($urandom_range(0, 9) == 0) beats = $urandom_range(1, beats);
    sent  = 0;
    send_beat(mk(CMD_BPUSH, $urandom(), BLEN_W'(n), IDX_W'($urandom_range(0, 1023))));
    sent++;
    for (k = 1; k < beats; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_single();
        sent++;
      end
      send_beat(mk(CMD_BPUSH, $urandom(), BLEN_W'($urandom_range(0, 127)),
                   IDX_W'($urandom_range(0, 1023))));
      sent++;
    end
  endtask

  task automatic run_phase(int quota);
    int issued;
    int r;
    int extra;
    int unsigned n;
    issued  = 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (issued < quota) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_beat(mk(CMD_PUSH, $urandom(), BLEN_W'($urandom_range(0, 127)),
                     IDX_W'($urandom_range(0, 1023))));
        issued++;
      end else if (r < 50) begin
        send_beat(mk(CMD_POP, $urandom(), BLEN_W'($urandom_range(0, 127)),
                     IDX_W'($urandom_range(0, 1023))));
        issued++;
      end else if (r < 60) begin
        send_beat(mk(CMD_PEEK, $urandom(), BLEN_W'($urandom_range(0, 127)),
                     IDX_W'($urandom_range(0, 1023))));
        issued++;
      end else if (r < 75) begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                        : $urandom_range(0, min_u(cur_size, 8));
        send_beat(mk(CMD_BPOP, $urandom(), BLEN_W'(n), IDX_W'($urandom_range(0, 1023))));
        issued++;
      end else if (r < 94) begin
        send_burst_push(extra);
        issued += extra;
      end else begin
        // Noise: any field value, undefined commands included
        send_beat(mk(CMD_W'($urandom_range(0, 7)), $urandom(),
                     BLEN_W'($urandom_range(0, 127)), IDX_W'($urandom_range(0, 1023))));
        issued++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // Receiver back-pressure, with one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 1)) begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 100)) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [CFG_W-1:0] sizes [10];
    int p;
    sizes = '{11'd2047, 11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd16, 11'd0, 11'd64, 11'd1024};
    sizes[7] = CFG_W'($urandom_range(1, 80));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty refusals, extremes, peek wrap, bursts and undefined codes
    send_beat(mk(CMD_POP,     32'h0,        7'd0,   10'd0));
    send_beat(mk(CMD_BPOP,    32'h0,        7'd0,   10'd0));
    send_beat(mk(CMD_BPOP,    32'h0,        7'd5,   10'd0));
    send_beat(mk(CMD_PEEK,    32'h0,        7'd0,   10'd1023));
    send_beat(mk(CMD_PUSH,    32'h0000_0000, 7'd0,  10'd0));
    send_beat(mk(CMD_PUSH,    32'hFFFF_FFFF, 7'd127, 10'd1023));
    send_beat(mk(CMD_PEEK,    32'h0,        7'd0,   10'd1));
    send_beat(mk(CMD_PEEK,    32'h0,        7'd0,   10'd1023));
    send_beat(mk(CMD_BPUSH,   32'hA5A5_5A5A, 7'd0,  10'd0));
    send_beat(mk(CMD_BPUSH,   32'h1234_5678, 7'd3,  10'd0));
    send_beat(mk(CMD_POP,     32'h0,        7'd0,   10'd0));
    send_beat(mk(CMD_BPUSH,   32'h8765_4321, 7'd9,  10'd0));
    send_beat(mk(CMD_BPUSH,   32'h0F0F_F0F0, 7'd0,  10'd0));
    send_beat(mk(CMD_BPOP,    32'h0,        7'd127, 10'd0));
    send_beat(mk(CMD_BPOP,    32'h0,        7'd4,   10'd0));
    send_beat(mk(CMD_SPARE_5, 32'hFFFF_FFFF, 7'd1,  10'd2));
    send_beat(mk(CMD_SPARE_6, 32'h0,        7'd0,   10'd0));
    send_beat(mk(CMD_SPARE_7, 32'h5555_AAAA, 7'd64, 10'd512));

    // Size zero acts as one: full push, refused burst push
    write_size(11'd0);
    send_beat(mk(CMD_PUSH,  32'hDEAD_BEEF, 7'd0, 10'd0));
    send_beat(mk(CMD_PUSH,  32'hCAFE_F00D, 7'd0, 10'd0));
    send_beat(mk(CMD_PEEK,  32'h0,         7'd0, 10'd1023));
    send_beat(mk(CMD_BPUSH, 32'h1111_1111, 7'd2, 10'd0));
    send_beat(mk(CMD_BPUSH, 32'h2222_2222, 7'd2, 10'd0));
    send_beat(mk(CMD_POP,   32'h0,         7'd0, 10'd0));

    // Random phases over a spread of sizes
    for (p = 0; p < 10; p++) begin
      write_size(sizes[p]);
      if (p == 2) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/wrfifo_pkg.sv
sv/wrfifo_mod.sv
sv/wrfifo_dp.sv
sv/wrfifo_ctrl.sv
sv/word_ring_fifo_with_burst_and_peek.sv
verif/ring_fifo_checker.sv
verif/tb_top.sv
